### sv/glyph_text_layout_unit_macros.svh
// ----------------------------------------------------------------------------
// Glyph text layout unit assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef GLYPH_TEXT_LAYOUT_UNIT_MACROS_SVH
`define GLYPH_TEXT_LAYOUT_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define GTL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GTL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define GTL_ASSERT_IMP(label, clk, rst, ante, cons, msg)

`define GTL_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### sv/gtl_pkg.sv
// ----------------------------------------------------------------------------
// Glyph text layout package
// Request, response, table entry and command types, function and CSR codes.
// ----------------------------------------------------------------------------
package gtl_pkg;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_PLACE = 1'b1;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_GLYPH_COUNT = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EM_SIZE     = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FB_WIDTH    = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FB_HEIGHT   = 4'd3;

   localparam logic [12:0] FB_WIDTH_RST  = 13'd320;
   localparam logic [12:0] FB_HEIGHT_RST = 13'd240;

   typedef struct packed {
      logic               func;
      logic [7:0]         entry_index;
      logic [7:0]         glyph_code;
      logic [7:0]         glyph_width;
      logic [7:0]         glyph_height;
      logic signed [7:0]  glyph_hshift;
      logic signed [7:0]  glyph_vshift;
      logic [31:0]        glyph_offset;
      logic               string_start;
      logic signed [15:0] start_x;
      logic signed [15:0] start_y;
   } gtl_req_type;

   typedef struct packed {
      logic               found;
      logic signed [15:0] draw_x;
      logic signed [15:0] draw_y;
      logic signed [31:0] origin_address;
      logic [7:0]         out_width;
      logic [7:0]         out_height;
      logic [31:0]        out_offset;
   } gtl_rsp_type;

   // one glyph table row
   typedef struct packed {
      logic [7:0]  code;
      logic [7:0]  width;
      logic [7:0]  height;
      logic [7:0]  hshift;
      logic [7:0]  vshift;
      logic [31:0] offset;
   } gtl_entry_type;

   // controller to datapath
   typedef struct packed {
      logic accept_place;
      logic write_entry;
      logic rd_en;
      logic capture;
      logic do_pos;
      logic do_ofs;
      logic do_mul;
      logic emit;
      logic emit_found;
   } gtl_cmd_type;

endpackage

### sv/gtl_ram.sv
// ----------------------------------------------------------------------------
// Glyph text layout RAM
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module gtl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic             re,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### sv/gtl_ctrl.sv
// ----------------------------------------------------------------------------
// Glyph text layout controller
// Sequences table writes, the linear code search and the placement steps.
// ----------------------------------------------------------------------------
module gtl_ctrl #(
   parameter int MAX_GLYPHS = 256,
   localparam int CNT_W     = $clog2(MAX_GLYPHS + 1),
   localparam int IDX_W     = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 func,
   input  logic [CNT_W-1:0]     limit,
   input  logic                 code_match,
   output logic                 busy,
   output gtl_pkg::gtl_cmd_type cmd,
   output logic [IDX_W-1:0]     rd_addr
);

   import gtl_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SEARCH = 6'b000010,
      S_POS    = 6'b000100,
      S_OFS    = 6'b001000,
      S_MUL    = 6'b010000,
      S_EMIT   = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pend_ff, pend_in;
   logic             hit_ff, hit_in;
   logic             issue;

   assign issue   = (cnt_ff < limit);
   assign busy    = (state_ff != S_IDLE);
   assign rd_addr = cnt_ff[IDX_W-1:0];

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      pend_in  = pend_ff;
      hit_in   = hit_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (func == FUNC_PLACE) begin
                  cmd.accept_place = 1'b1;
                  cnt_in           = '0;
                  pend_in          = 1'b0;
                  hit_in           = 1'b0;
                  state_in         = S_SEARCH;
               end else begin
                  cmd.write_entry = 1'b1;
               end
            end
         end
         S_SEARCH: begin
            // data of the read issued last cycle is checked while the next read goes out
            if (pend_ff && code_match) begin
               cmd.capture = 1'b1;
               hit_in      = 1'b1;
               pend_in     = 1'b0;
               state_in    = S_POS;
            end else if (issue) begin
               cmd.rd_en = 1'b1;
               cnt_in    = cnt_ff + 1'b1;
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = S_EMIT;
               end
            end
         end
         S_POS: begin
            cmd.do_pos = 1'b1;
            state_in   = S_OFS;
         end
         S_OFS: begin
            cmd.do_ofs = 1'b1;
            state_in   = S_MUL;
         end
         S_MUL: begin
            cmd.do_mul = 1'b1;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            cmd.emit       = 1'b1;
            cmd.emit_found = hit_ff;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
         hit_ff   <= hit_in;
      end
   end

endmodule

### sv/gtl_datapath.sv
// ----------------------------------------------------------------------------
// Glyph text layout datapath
// Glyph table RAM, pen registers, placement arithmetic and response register.
// ----------------------------------------------------------------------------
module gtl_datapath #(
   parameter int MAX_GLYPHS = 256,
   localparam int IDX_W     = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  gtl_pkg::gtl_cmd_type cmd,
   input  gtl_pkg::gtl_req_type req,
   input  logic [IDX_W-1:0]     rd_addr,
   input  logic [15:0]          em_size,
   input  logic [12:0]          fb_width,
   input  logic [12:0]          fb_height,
   output logic                 code_match,
   output logic                 rsp_valid,
   output gtl_pkg::gtl_rsp_type rsp
);

   import gtl_pkg::*;

   localparam int          ENTRY_W = $bits(gtl_entry_type);
   localparam logic [16:0] MAX_G   = 17'(MAX_GLYPHS);

   gtl_entry_type      wr_entry, rd_entry, entry_ff;
   logic [ENTRY_W-1:0] ram_rdata;
   logic [IDX_W-1:0]   ram_addr;
   logic               ram_we;

   logic [7:0]  code_ff;
   logic [15:0] pen_x_ff, pen_x_in;
   logic [15:0] pen_y_ff, pen_y_in;
   logic        first_ff, first_in;
   logic [15:0] dx_ff, dy_ff, px;
   logic [31:0] ax_ff, ay_ff, prod_ff;
   gtl_rsp_type rsp_ff, rsp_in;
   logic        rsp_valid_ff;

   // table write; slots beyond the table are dropped
   assign ram_we   = cmd.write_entry && ({9'd0, req.entry_index} < MAX_G);
   assign ram_addr = cmd.write_entry ? IDX_W'(req.entry_index) : rd_addr;

   always_comb begin
      wr_entry.code   = req.glyph_code;
      wr_entry.width  = req.glyph_width;
      wr_entry.height = req.glyph_height;
      wr_entry.hshift = req.glyph_hshift;
      wr_entry.vshift = req.glyph_vshift;
      wr_entry.offset = req.glyph_offset;
   end

   gtl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_GLYPHS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .re    (cmd.rd_en),
      .addr  (ram_addr),
      .wdata (wr_entry),
      .rdata (ram_rdata)
   );

   assign rd_entry   = ram_rdata;
   assign code_match = (rd_entry.code == code_ff);

   // kerning is skipped for the first glyph of a string
   assign px = first_ff ? pen_x_ff
                        : pen_x_ff + {{8{entry_ff.hshift[7]}}, entry_ff.hshift};

   always_comb begin
      pen_x_in = pen_x_ff;
      pen_y_in = pen_y_ff;
      first_in = first_ff;
      rsp_in   = rsp_ff;
      if (cmd.accept_place && req.string_start) begin
         pen_x_in = req.start_x;
         pen_y_in = req.start_y;
         first_in = 1'b1;
      end
      if (cmd.do_pos) begin
         pen_x_in = px;
         first_in = 1'b0;
      end
      if (cmd.emit) begin
         if (cmd.emit_found) begin
            rsp_in.found          = 1'b1;
            rsp_in.draw_x         = dx_ff;
            rsp_in.draw_y         = dy_ff;
            rsp_in.origin_address = prod_ff + ay_ff;
            rsp_in.out_width      = entry_ff.width;
            rsp_in.out_height     = entry_ff.height;
            rsp_in.out_offset     = entry_ff.offset;
            pen_x_in              = pen_x_ff + {8'd0, entry_ff.width} + 16'd1;
         end else begin
            rsp_in   = '0;
            pen_x_in = pen_x_ff + {2'd0, em_size[15:2]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         pen_x_ff     <= pen_x_in;
         pen_y_ff     <= pen_y_in;
         first_ff     <= first_in;
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (cmd.accept_place) begin
         code_ff <= req.glyph_code;
      end
      if (cmd.capture) begin
         entry_ff <= rd_entry;
      end
      if (cmd.do_pos) begin
         dx_ff <= px;
         dy_ff <= pen_y_ff - {8'd0, entry_ff.height}
                  + {{8{entry_ff.vshift[7]}}, entry_ff.vshift};
      end
      if (cmd.do_ofs) begin
         ax_ff <= {19'd0, fb_width} - 32'd1 - {{16{dx_ff[15]}}, dx_ff};
         ay_ff <= {19'd0, fb_height} - 32'd1 - {{16{dy_ff[15]}}, dy_ff};
      end
      if (cmd.do_mul) begin
         prod_ff <= 32'(ax_ff * {19'd0, fb_height});
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

### sv/glyph_text_layout_unit.sv
// ----------------------------------------------------------------------------
// Glyph text layout unit
// Glyph table with linear code search and pen-based text placement.
// ----------------------------------------------------------------------------
//
// channel   ports                                  handshake
// -------   -------------------------------------  ------------------------------
// request   start, busy, req_payload               taken when start & !busy
// response  rsp_valid, rsp_payload                 one-cycle strobe, no backpressure
// csr       csr_valid, csr_ready, csr_index/data   written when valid & ready
//
// A load request writes one table row in the cycle it is taken; busy stays low.
// A place request scans rows 0 .. min(glyph_count, MAX_GLYPHS)-1, one RAM read
// per cycle through the single table port, and stops at the lowest matching row.
// The response strobe follows the last busy cycle.
// Reset is synchronous: pen at (0,0), first glyph flag set, CSRs to defaults.
// The table is not cleared; rows must be loaded before they are searched.
// Responses cannot be stalled; a new request can be taken while one is shown.
//
`include "glyph_text_layout_unit_macros.svh"

module glyph_text_layout_unit #(
   parameter int MAX_GLYPHS = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 start,
   output logic                                 busy,
   input  gtl_pkg::gtl_req_type                 req_payload,
   // response channel
   output logic                                 rsp_valid,
   output gtl_pkg::gtl_rsp_type                 rsp_payload,
   // configuration channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gtl_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [gtl_pkg::CSR_DATA_W-1:0]       csr_data
);

   import gtl_pkg::*;

   localparam int          CNT_W = $clog2(MAX_GLYPHS + 1);
   localparam int          IDX_W = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
   localparam logic [16:0] MAX_G = 17'(MAX_GLYPHS);

   // CSR file
   logic [8:0]  glyph_count_ff;
   logic [15:0] em_size_ff;
   logic [12:0] fb_width_ff;
   logic [12:0] fb_height_ff;
   logic        csr_wr;

   // controller / datapath links
   gtl_cmd_type      cmd;
   logic [CNT_W-1:0] limit;
   logic [IDX_W-1:0] rd_addr;
   logic             code_match;
   logic [16:0]      count_ext;

   // CSR writes are held off while a place request is in flight
   assign csr_ready = !busy;
   assign csr_wr    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_count_ff <= '0;
         em_size_ff     <= '0;
         fb_width_ff    <= FB_WIDTH_RST;
         fb_height_ff   <= FB_HEIGHT_RST;
      end else if (csr_wr) begin
         unique case (csr_index)
            CSR_GLYPH_COUNT: glyph_count_ff <= csr_data[8:0];
            CSR_EM_SIZE:     em_size_ff     <= csr_data;
            CSR_FB_WIDTH:    fb_width_ff    <= csr_data[12:0];
            CSR_FB_HEIGHT:   fb_height_ff   <= csr_data[12:0];
            default: begin
               // unmapped index: write dropped
            end
         endcase
      end
   end

   // search bound: glyph_count clipped to the table depth
   assign count_ext = {8'd0, glyph_count_ff};
   assign limit     = (count_ext < MAX_G) ? CNT_W'(count_ext) : CNT_W'(MAX_G);

   gtl_ctrl #(
      .MAX_GLYPHS (MAX_GLYPHS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .func       (req_payload.func),
      .limit      (limit),
      .code_match (code_match),
      .busy       (busy),
      .cmd        (cmd),
      .rd_addr    (rd_addr)
   );

   gtl_datapath #(
      .MAX_GLYPHS (MAX_GLYPHS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req        (req_payload),
      .rd_addr    (rd_addr),
      .em_size    (em_size_ff),
      .fb_width   (fb_width_ff),
      .fb_height  (fb_height_ff),
      .code_match (code_match),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp_payload)
   );

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------

   // each place request gives a single strobe
   `GTL_ASSERT_NXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "response strobe longer than one cycle")

   // a place request always occupies the engine
   `GTL_ASSERT_NXT(a_place_busy, clock, reset, start && !busy && req_payload.func == FUNC_PLACE, busy, "place request did not raise busy")

   // a load request completes in its accept cycle
   `GTL_ASSERT_NXT(a_load_idle, clock, reset, start && !busy && req_payload.func == FUNC_LOAD, !busy && !rsp_valid, "load request left the engine busy")

   // a miss reports all-zero placement fields
   `GTL_ASSERT_IMP(a_miss_zero, clock, reset, rsp_valid && !rsp_payload.found, rsp_payload.draw_x == 16'sd0 && rsp_payload.draw_y == 16'sd0 && rsp_payload.origin_address == 32'sd0 && rsp_payload.out_offset == 32'd0, "miss response carries nonzero fields")

endmodule

### verif/glyph_text_layout_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph text layout unit testbench
// Loads glyph rows, places strings of characters and checks each placement
// against a cycle-free prediction of pen movement, lookup and origin address.
// A short directed run covers field extremes and the pen corner cases; a
// longer random run then sweeps table sizes, font sizes and screen sizes.
// ----------------------------------------------------------------------------
module glyph_text_layout_unit_tb;
   import gtl_pkg::*;

   localparam int TABLE_DEPTH   = 256;
   localparam int SETTLE_CYCLES = 16;    // covers a load still in flight
   localparam int DRAIN_CYCLES  = 300;   // longer than a full 256-row scan

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   gtl_req_type           req_payload;
   logic                  rsp_valid;
   gtl_rsp_type           rsp_payload;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // predicted glyph table, pen and CSR copies
   gtl_entry_type         glyph_table_copy [TABLE_DEPTH];
   logic [15:0]           pen_x_exp;
   logic [15:0]           pen_y_exp;
   logic                  first_glyph_exp;
   logic [8:0]            glyph_count_cfg;
   logic [15:0]           em_size_cfg;
   logic [12:0]           screen_w_cfg;
   logic [12:0]           screen_h_cfg;

   // placements predicted but not yet seen on the response port
   gtl_rsp_type           pending_placements [$];
   int unsigned           mismatch_count = 0;
   bit                    no_gaps = 1'b0;

   glyph_text_layout_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop, far beyond the slowest legal run (~9 ms)
   initial begin
      #50ms;
      $error("timeout: stimulus or responses stalled");
      $display("status: fail");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Prediction: applies one accepted request to the local state and queues
   // the placement it must produce. Loads produce nothing.
   // ------------------------------------------------------------------------
   function automatic void predict_layout(input gtl_req_type r);
      gtl_rsp_type   res;
      gtl_entry_type hit;
      int unsigned   limit;
      bit            found;
      logic [15:0]   dy;
      logic [31:0]   ax;
      logic [31:0]   ay;
      if (r.func == FUNC_LOAD) begin
         glyph_table_copy[r.entry_index] = '{code: r.glyph_code, width: r.glyph_width,
                                             height: r.glyph_height,
                                             hshift: r.glyph_hshift,
                                             vshift: r.glyph_vshift,
                                             offset: r.glyph_offset};
         return;
      end
      // string start reloads the pen before the lookup
      if (r.string_start) begin
         pen_x_exp       = r.start_x;
         pen_y_exp       = r.start_y;
         first_glyph_exp = 1'b1;
      end
      res   = '0;
      hit   = '0;
      found = 1'b0;
      limit = (glyph_count_cfg > TABLE_DEPTH) ? TABLE_DEPTH : glyph_count_cfg;
      // lowest matching row wins
      for (int i = 0; i < limit && !found; i++) begin
         if (glyph_table_copy[i].code == r.glyph_code) begin
            hit   = glyph_table_copy[i];
            found = 1'b1;
         end
      end
      if (!found) begin
         // miss: all-zero result, quarter font size advance, first flag kept
         pen_x_exp = pen_x_exp + {2'b00, em_size_cfg[15:2]};
         pending_placements.push_back(res);
         return;
      end
      // kerning shift skipped on the first glyph of a string
      if (!first_glyph_exp)
         pen_x_exp = pen_x_exp + {{8{hit.hshift[7]}}, hit.hshift};
      first_glyph_exp = 1'b0;
      dy = pen_y_exp - {8'h00, hit.height} + {{8{hit.vshift[7]}}, hit.vshift};
      // rotated framebuffer: column-major from the far corner, wraps at 32 bits
      ax = {19'd0, screen_w_cfg} - 32'd1 - {{16{pen_x_exp[15]}}, pen_x_exp};
      ay = {19'd0, screen_h_cfg} - 32'd1 - {{16{dy[15]}}, dy};
      res.found          = 1'b1;
      res.draw_x         = pen_x_exp;
      res.draw_y         = dy;
      res.origin_address = ax * {19'd0, screen_h_cfg} + ay;
      res.out_width      = hit.width;
      res.out_height     = hit.height;
      res.out_offset     = hit.offset;
      pending_placements.push_back(res);
      pen_x_exp = pen_x_exp + {8'h00, hit.width} + 16'd1;
   endfunction

   // ------------------------------------------------------------------------
   // Response checking: signals are read at the edge that takes the strobe,
   // i.e. before any update made at that edge.
   // ------------------------------------------------------------------------
   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      gtl_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_placements.size() == 0) begin
            $error("response with no request outstanding");
            mismatch_count++;
         end else begin
            want = pending_placements.pop_front();
            compare_field("found",          want.found,          rsp_payload.found);
            compare_field("draw_x",         want.draw_x,         rsp_payload.draw_x);
            compare_field("draw_y",         want.draw_y,         rsp_payload.draw_y);
            compare_field("origin_address", want.origin_address,
                          rsp_payload.origin_address);
            compare_field("out_width",      want.out_width,      rsp_payload.out_width);
            compare_field("out_height",     want.out_height,     rsp_payload.out_height);
            compare_field("out_offset",     want.out_offset,     rsp_payload.out_offset);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request builders: fields a request does not use carry random noise
   // ------------------------------------------------------------------------
   function automatic gtl_req_type random_request();
      gtl_req_type r;
      r.func         = 1'($urandom_range(0, 1));
      r.entry_index  = 8'($urandom);
      r.glyph_code   = 8'($urandom);
      r.glyph_width  = 8'($urandom);
      r.glyph_height = 8'($urandom);
      r.glyph_hshift = 8'($urandom);
      r.glyph_vshift = 8'($urandom);
      r.glyph_offset = 32'($urandom);
      r.string_start = 1'($urandom_range(0, 1));
      r.start_x      = 16'($urandom);
      r.start_y      = 16'($urandom);
      return r;
   endfunction

   function automatic gtl_req_type make_load(input logic [7:0] idx, input logic [7:0] code,
                                             input logic [7:0] w, input logic [7:0] h,
                                             input logic [7:0] hs, input logic [7:0] vs,
                                             input logic [31:0] off);
      gtl_req_type r;
      r              = random_request();
      r.func         = FUNC_LOAD;
      r.entry_index  = idx;
      r.glyph_code   = code;
      r.glyph_width  = w;
      r.glyph_height = h;
      r.glyph_hshift = hs;
      r.glyph_vshift = vs;
      r.glyph_offset = off;
      return r;
   endfunction

   function automatic gtl_req_type make_place(input logic [7:0] code, input logic ss,
                                              input logic [15:0] sx, input logic [15:0] sy);
      gtl_req_type r;
      r              = random_request();
      r.func         = FUNC_PLACE;
      r.glyph_code   = code;
      r.string_start = ss;
      r.start_x      = sx;
      r.start_y      = sy;
      return r;
   endfunction

   // small alphabet most of the time so duplicate codes are common
   function automatic logic [7:0] random_code();
      return ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 63)) : 8'($urandom);
   endfunction

   function automatic logic [15:0] random_coord();
      case ($urandom_range(0, 19))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Request driver. start stays high after a request is taken; the next
   // call either swaps the payload in the same step or drops start for a gap.
   // ------------------------------------------------------------------------
   task automatic issue_request(input gtl_req_type r);
      int unsigned roll;
      int unsigned gap;
      gap = 0;
      if (!no_gaps) begin
         roll = $urandom_range(0, 99);
         if (roll < 55)      gap = 0;
         else if (roll < 88) gap = $urandom_range(1, 3);
         else if (roll < 97) gap = $urandom_range(4, 15);
         else                gap = $urandom_range(20, 60);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
      predict_layout(r);
   endtask

   // wait until every placement has come back and any load has settled
   task automatic drain_layout();
      start <= 1'b0;
      while (pending_placements.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // all four CSRs, written back to back once the unit is idle
   task automatic apply_layout_config(input logic [8:0] count, input logic [15:0] font,
                                      input logic [12:0] sw, input logic [12:0] sh);
      logic [CSR_IDX_W-1:0]  idx  [4];
      logic [CSR_DATA_W-1:0] vals [4];
      drain_layout();
      idx  = '{CSR_GLYPH_COUNT, CSR_EM_SIZE, CSR_FB_WIDTH, CSR_FB_HEIGHT};
      vals = '{16'(count), font, 16'(sw), 16'(sh)};
      for (int k = 0; k < 4; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_data  <= vals[k];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid       <= 1'b0;
      glyph_count_cfg = count;
      em_size_cfg     = font;
      screen_w_cfg    = sw;
      screen_h_cfg    = sh;
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Empty table after reset: every place misses. Pen starts at (0,0) and
   // with font size 0 does not move; then the largest miss advance.
   task automatic test_reset_pen();
      issue_request(make_place(8'h41, 1'b0, 16'h0000, 16'h0000));
      issue_request(make_place(8'h00, 1'b1, 16'h7FFF, 16'h8000));
      apply_layout_config(9'd0, 16'hFFFF, FB_WIDTH_RST, FB_HEIGHT_RST);
      issue_request(make_place(8'hFF, 1'b0, 16'h0000, 16'h0000));
   endtask

   // Eight rows with extreme sizes, shifts and offsets. Row 3 repeats the
   // code of row 0 and must never win. Covers first-glyph kerning skip, pen
   // wrap, misses inside a string and a miss right after a string start.
   task automatic test_table_hits();
      issue_request(make_load(8'd0, 8'h41, 8'h00, 8'h00, 8'h80, 8'h7F, 32'h0000_0000));
      issue_request(make_load(8'd1, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h80, 32'hFFFF_FFFF));
      issue_request(make_load(8'd2, 8'h00, 8'h07, 8'h0C, 8'hFF, 8'h01, 32'h1234_5678));
      issue_request(make_load(8'd3, 8'h41, 8'h09, 8'h09, 8'h05, 8'h05, 32'h5555_5555));
      issue_request(make_load(8'd4, 8'h80, 8'h10, 8'h20, 8'h80, 8'h80, 32'hAAAA_AAAA));
      issue_request(make_load(8'd5, 8'h7F, 8'h01, 8'hFF, 8'h7F, 8'h7F, 32'h0000_0001));
      issue_request(make_load(8'd6, 8'h55, 8'h03, 8'h08, 8'h00, 8'h00, 32'h8000_0000));
      issue_request(make_load(8'd7, 8'hAA, 8'h05, 8'h05, 8'hFE, 8'h02, 32'h7FFF_FFFF));
      apply_layout_config(9'd8, 16'hFFFF, 13'd320, 13'd240);
      issue_request(make_place(8'h41, 1'b1, 16'h7FFF, 16'h8000));
      issue_request(make_place(8'hFF, 1'b0, 16'h0000, 16'h0000));
      issue_request(make_place(8'h00, 1'b0, 16'h0000, 16'h0000));
      issue_request(make_place(8'h13, 1'b0, 16'h0000, 16'h0000));
      issue_request(make_place(8'h13, 1'b1, 16'h8000, 16'h7FFF));
      issue_request(make_place(8'h80, 1'b0, 16'h0000, 16'h0000));
      issue_request(make_place(8'h55, 1'b0, 16'h0000, 16'h0000));
   endtask

   // 4096 by 4096 and 1 by 1 framebuffers, address arithmetic wrapping
   task automatic test_screen_extremes();
      apply_layout_config(9'd8, 16'h0000, 13'd4096, 13'd4096);
      issue_request(make_place(8'hAA, 1'b1, 16'h0000, 16'h0000));
      issue_request(make_place(8'h7F, 1'b0, 16'h0000, 16'h0000));
      apply_layout_config(9'd8, 16'h0000, 13'd1, 13'd1);
      issue_request(make_place(8'h41, 1'b1, 16'hFFFF, 16'h0001));
      issue_request(make_place(8'h00, 1'b0, 16'h0000, 16'h0000));
   endtask

   // Full table refill, then phases of strings with mostly-hitting codes,
   // stray loads and noise places. -1 in a phase table means random.
   task automatic test_random_layout();
      int          count_sel [10] = '{1, 16, 256, 5, 32, 0, 64, 256, 9, 128};
      int          font_sel  [10] = '{0, 65535, -1, -1, -1, 65535, -1, -1, 4, -1};
      int          sw_sel    [10] = '{-1, -1, 1, 4096, -1, -1, -1, 4096, 1, -1};
      int          sh_sel    [10] = '{-1, -1, 4096, 1, -1, -1, -1, 4096, 1, -1};
      int          sent;
      int          len;
      int          roll;
      int unsigned limit;
      bit          paused;
      logic [7:0]  code;
      no_gaps = 1'b0;
      // every row written before any search can reach it
      for (int i = 0; i < TABLE_DEPTH; i++)
         issue_request(make_load(8'(i), random_code(), 8'($urandom), 8'($urandom),
                                 8'($urandom), 8'($urandom), $urandom));
      paused = 1'b0;
      for (int ph = 0; ph < 10; ph++) begin
         apply_layout_config(9'(count_sel[ph]),
                             (font_sel[ph] < 0) ? 16'($urandom) : 16'(font_sel[ph]),
                             (sw_sel[ph] < 0) ? 13'($urandom_range(1, 4096))
                                              : 13'(sw_sel[ph]),
                             (sh_sel[ph] < 0) ? 13'($urandom_range(1, 4096))
                                              : 13'(sh_sel[ph]));
         // back-to-back stretch in some phases
         no_gaps = (ph % 4 == 2);
         limit   = (glyph_count_cfg > TABLE_DEPTH) ? TABLE_DEPTH : glyph_count_cfg;
         sent    = 0;
         while (sent < 110) begin
            roll = $urandom_range(0, 99);
            if (roll < 82) begin
               // a string: start on the first character, then continue the pen
               len = $urandom_range(1, 10);
               for (int j = 0; j < len; j++) begin
                  if (limit > 0 && $urandom_range(0, 3) != 0)
                     code = glyph_table_copy[$urandom_range(0, limit - 1)].code;
                  else
                     code = random_code();
                  issue_request(make_place(code, (j == 0), random_coord(), random_coord()));
               end
               sent += len;
            end else if (roll < 92) begin
               issue_request(make_load(8'($urandom), random_code(), 8'($urandom),
                                       8'($urandom), 8'($urandom), 8'($urandom), $urandom));
               sent++;
            end else begin
               issue_request(make_place(8'($urandom), 1'($urandom), random_coord(),
                                        random_coord()));
               sent++;
            end
            // sender holds off mid-phase until the pipeline is empty
            if ((ph == 4 && sent >= 55 && !paused) || $urandom_range(0, 99) == 0) begin
               drain_layout();
               paused = 1'b1;
            end
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_payload     = '0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      pen_x_exp       = 16'h0000;
      pen_y_exp       = 16'h0000;
      first_glyph_exp = 1'b1;
      glyph_count_cfg = 9'd0;
      em_size_cfg     = 16'd0;
      screen_w_cfg    = FB_WIDTH_RST;
      screen_h_cfg    = FB_HEIGHT_RST;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_pen();
      test_table_hits();
      test_screen_extremes();
      test_random_layout();

      drain_layout();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
